/* sv/lhpc_pkg.sv */
// Shared types and constants for the hash-page cache controller.
// No dependencies; every other file imports this package.
package lhpc_pkg;

  // Fixed field widths of the request and response transactions.
  localparam int GS_W       = 2;   // group slot
  localparam int HI_W       = 13;  // digest index within a group
  localparam int BASE_W     = 28;  // flash base register
  localparam int FA_W       = 29;  // fetch address
  localparam int OFF_W      = 12;  // digest byte offset in a page
  localparam int SLOT_OUT_W = 3;   // cache slot as reported
  localparam int SIU_W      = 4;   // slots_in_use register
  localparam int GEN_W      = 4;   // group_enable register

  localparam int GROUP_SLOTS      = 4;
  localparam int PAGE_BYTES       = 512 * 5;
  localparam int DIGEST_BYTES     = 20;
  localparam int DIGESTS_PER_PAGE = PAGE_BYTES / DIGEST_BYTES;  // 128
  localparam int PIDX_W           = HI_W - $clog2(DIGESTS_PER_PAGE);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = BASE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_ENABLE = 3'd0,
    REG_GROUP_BASE_0 = 3'd1,
    REG_GROUP_BASE_1 = 3'd2,
    REG_GROUP_BASE_2 = 3'd3,
    REG_GROUP_BASE_3 = 3'd4,
    REG_SLOTS_IN_USE = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GEN_W-1:0]                    group_enable;
    logic [GROUP_SLOTS-1:0][BASE_W-1:0]  group_base;
    logic [SIU_W-1:0]                    slots_in_use;
  } cfg_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic accept;  // latch request, start map read
    logic commit;  // update cache state, load response register
  } ctrl_cmd_t;

  typedef struct packed {
    logic rsp_valid;  // response register occupied
  } dp_status_t;

endpackage

/* sv/lhpc_if.sv */
// Request and response channel interfaces of the hash-page cache controller.
// Depends on lhpc_pkg for field widths.
interface lhpc_req_if;
  import lhpc_pkg::*;
  logic              valid;
  logic              ready;
  logic [GS_W-1:0]   group_slot;
  logic [HI_W-1:0]   hash_index;

  modport source (output valid, group_slot, hash_index, input ready);
  modport sink   (input valid, group_slot, hash_index, output ready);
endinterface

interface lhpc_rsp_if;
  import lhpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic                  hit;
  logic                  evicted;
  logic [SLOT_OUT_W-1:0] cache_slot;
  logic [FA_W-1:0]       fetch_address;
  logic [OFF_W-1:0]      hash_byte_offset;

  modport source (output valid, found, hit, evicted, cache_slot, fetch_address,
                  hash_byte_offset, input ready);
  modport sink   (input valid, found, hit, evicted, cache_slot, fetch_address,
                  hash_byte_offset, output ready);
endinterface

/* sv/lhpc_cfg_regs.sv */
// Configuration register bank: enable mask, group bases, slots_in_use.
// Depends on lhpc_pkg.
module lhpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lhpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lhpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lhpc_pkg::cfg_t                cfg_o
);
  import lhpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GROUP_ENABLE: cfg_d.group_enable  = cfg_wdata_i[GEN_W-1:0];
        REG_GROUP_BASE_0: cfg_d.group_base[0] = cfg_wdata_i[BASE_W-1:0];
        REG_GROUP_BASE_1: cfg_d.group_base[1] = cfg_wdata_i[BASE_W-1:0];
        REG_GROUP_BASE_2: cfg_d.group_base[2] = cfg_wdata_i[BASE_W-1:0];
        REG_GROUP_BASE_3: cfg_d.group_base[3] = cfg_wdata_i[BASE_W-1:0];
        REG_SLOTS_IN_USE: cfg_d.slots_in_use  = cfg_wdata_i[SIU_W-1:0];
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.group_enable <= '0;
      cfg_q.group_base   <= '0;
      cfg_q.slots_in_use <= SIU_W'(8);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/lhpc_ctrl.sv */
// Sequencing FSM: accept a request, then commit once the response slot frees.
// Depends on lhpc_pkg.
module lhpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  logic                  rsp_ready_i,
  input  lhpc_pkg::dp_status_t  status_i,
  output lhpc_pkg::ctrl_cmd_t   cmd_o
);
  import lhpc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        rsp_free;

  assign rsp_free = !status_i.rsp_valid || rsp_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_valid_i) state_d = ST_LOOKUP;
      ST_LOOKUP: if (rsp_free)    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    cmd_o.accept  = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
      end
      ST_LOOKUP: cmd_o.commit = rsp_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/lhpc_dp.sv */
// Datapath: request registers, page table (valid flops + slot memory),
// LRU ranks, slot owners and the response register. Depends on lhpc_pkg.
module lhpc_dp #(
  parameter int CACHE_SLOTS     = 8,
  parameter int PAGES_PER_GROUP = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lhpc_pkg::cfg_t                 cfg_i,
  input  lhpc_pkg::ctrl_cmd_t            cmd_i,
  output lhpc_pkg::dp_status_t           status_o,
  input  logic [lhpc_pkg::GS_W-1:0]      req_group_slot_i,
  input  logic [lhpc_pkg::HI_W-1:0]      req_hash_index_i,
  input  logic                           rsp_ready_i,
  output logic                           rsp_valid_o,
  output logic                           rsp_found_o,
  output logic                           rsp_hit_o,
  output logic                           rsp_evicted_o,
  output logic [lhpc_pkg::SLOT_OUT_W-1:0] rsp_cache_slot_o,
  output logic [lhpc_pkg::FA_W-1:0]      rsp_fetch_address_o,
  output logic [lhpc_pkg::OFF_W-1:0]     rsp_hash_byte_offset_o
);
  import lhpc_pkg::*;

  localparam int SLOT_W    = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W     = $clog2(CACHE_SLOTS + 1);
  localparam int LIM_W     = (CNT_W > SIU_W) ? CNT_W : SIU_W;
  localparam int MAP_DEPTH = GROUP_SLOTS * PAGES_PER_GROUP;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int PG_W      = (PAGES_PER_GROUP > 1) ? $clog2(PAGES_PER_GROUP) : 1;

  // Request decode (accept cycle)
  logic [PIDX_W-1:0] in_pidx;
  logic [OFF_W-1:0]  in_off;
  logic [MAP_AW-1:0] in_entry;
  logic              in_ok;

  assign in_pidx  = PIDX_W'(req_hash_index_i / DIGESTS_PER_PAGE);
  assign in_off   = OFF_W'(OFF_W'(req_hash_index_i % DIGESTS_PER_PAGE)
                    * OFF_W'(DIGEST_BYTES));
  assign in_entry = MAP_AW'(req_group_slot_i) * MAP_AW'(PAGES_PER_GROUP)
                    + MAP_AW'(in_pidx);
  assign in_ok    = cfg_i.group_enable[req_group_slot_i]
                    && (32'(in_pidx) < 32'(PAGES_PER_GROUP));

  // Latched request
  logic [GS_W-1:0]   grp_q;
  logic [PIDX_W-1:0] pidx_q;
  logic [OFF_W-1:0]  off_q;
  logic [MAP_AW-1:0] entry_q;
  logic              ok_q;
  logic [FA_W-1:0]   page_off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      grp_q      <= req_group_slot_i;
      pidx_q     <= in_pidx;
      off_q      <= in_off;
      entry_q    <= in_entry;
      ok_q       <= in_ok;
      page_off_q <= FA_W'(in_pidx) * FA_W'(PAGE_BYTES);
    end
  end

  // Page table: valid flops cleared at reset, slot numbers in a memory
  logic [MAP_DEPTH-1:0] map_valid_q;
  logic [SLOT_W-1:0]    map_mem [MAP_DEPTH];
  logic [SLOT_W-1:0]    map_rd_q;
  logic [MAP_AW-1:0]    map_rd_addr;

  // Read the new entry on accept; while waiting, keep rereading the latched one.
  assign map_rd_addr = cmd_i.accept ? in_entry : entry_q;

  // LRU state
  logic [SLOT_W-1:0] rank_q [CACHE_SLOTS];
  logic [CNT_W-1:0]  taken_q;
  logic [GS_W-1:0]   own_grp_q [CACHE_SLOTS];
  logic [PG_W-1:0]   own_pg_q  [CACHE_SLOTS];

  // Lookup result (commit cycle)
  logic                   hit;
  logic                   take_free;
  logic                   evict;
  logic                   upd;
  logic [LIM_W-1:0]       lim_raw, lim;
  logic [CACHE_SLOTS-1:0] in_use;
  logic [CACHE_SLOTS-1:0] is_lru;
  logic [CACHE_SLOTS-1:0] inc;
  logic [SLOT_W-1:0]      victim;
  logic [SLOT_W-1:0]      slot_sel;
  logic [SLOT_W-1:0]      sel_rank;
  logic [MAP_AW-1:0]      old_entry;

  assign hit = map_valid_q[entry_q];

  always_comb begin
    lim_raw = (cfg_i.slots_in_use == '0) ? LIM_W'(1) : LIM_W'(cfg_i.slots_in_use);
    lim     = (lim_raw > LIM_W'(CACHE_SLOTS)) ? LIM_W'(CACHE_SLOTS) : lim_raw;
  end

  assign take_free = !hit && (LIM_W'(taken_q) < lim);
  assign evict     = !hit && !take_free;
  assign upd       = cmd_i.commit && ok_q;

  // Ranks of taken slots are a permutation of 0..taken-1, so the LRU slot
  // is the single one holding rank taken-1.
  always_comb begin
    victim = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      in_use[i] = CNT_W'(i) < taken_q;
      is_lru[i] = in_use[i] && (rank_q[i] == SLOT_W'(taken_q - CNT_W'(1)));
      if (is_lru[i]) victim = victim | SLOT_W'(i);
    end
  end

  always_comb begin
    if (hit)            slot_sel = map_rd_q;
    else if (take_free) slot_sel = SLOT_W'(taken_q);
    else                slot_sel = victim;
  end

  assign sel_rank  = rank_q[slot_sel];
  assign old_entry = MAP_AW'(own_grp_q[victim]) * MAP_AW'(PAGES_PER_GROUP)
                     + MAP_AW'(own_pg_q[victim]);

  // Taking a free slot ages every taken slot; otherwise only younger ones age.
  always_comb begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      inc[i] = in_use[i] && (take_free || (rank_q[i] < sel_rank));
    end
  end

  always_ff @(posedge clk_i) begin
    map_rd_q <= map_mem[map_rd_addr];
    if (upd && !hit) begin
      map_mem[entry_q]    <= slot_sel;
      own_grp_q[slot_sel] <= grp_q;
      own_pg_q[slot_sel]  <= PG_W'(pidx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_valid_q <= '0;
      taken_q     <= '0;
      for (int i = 0; i < CACHE_SLOTS; i++) rank_q[i] <= '0;
    end else if (upd) begin
      if (!hit) begin
        if (evict) map_valid_q[old_entry] <= 1'b0;
        map_valid_q[entry_q] <= 1'b1;
      end
      if (take_free) taken_q <= taken_q + CNT_W'(1);
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (inc[i]) rank_q[i] <= rank_q[i] + SLOT_W'(1);
      end
      rank_q[slot_sel] <= '0;
    end
  end

  // Response register
  logic rsp_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= cmd_i.commit || (rsp_valid_q && !rsp_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      rsp_found_o            <= ok_q;
      rsp_hit_o              <= ok_q && hit;
      rsp_evicted_o          <= ok_q && evict;
      rsp_cache_slot_o       <= ok_q ? SLOT_OUT_W'(slot_sel) : '0;
      rsp_fetch_address_o    <= (ok_q && !hit)
                                ? FA_W'(cfg_i.group_base[grp_q]) + page_off_q : '0;
      rsp_hash_byte_offset_o <= ok_q ? off_q : '0;
    end
  end

  assign rsp_valid_o        = rsp_valid_q;
  assign status_o.rsp_valid = rsp_valid_q;

  // Checks
  a_taken_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    taken_q <= CNT_W'(CACHE_SLOTS))
    else $error("slot count beyond cache size");

  a_single_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && evict |-> $onehot(is_lru))
    else $error("LRU ranks do not name a single victim");

  a_miss_maps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd && !hit |=> map_valid_q[$past(entry_q)])
    else $error("missed page not mapped after commit");

  a_newest_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd |=> rank_q[$past(slot_sel)] == '0)
    else $error("used slot not most recently used");

endmodule

/* sv/lru_hash_page_cache_controller.sv */
// Top level of the hash-page cache controller.
// Depends on lhpc_pkg, lhpc_if, lhpc_cfg_regs, lhpc_ctrl and lhpc_dp.
//
// Fully associative LRU cache controller for pages of hash digests (2560-byte
// pages of 128 digests of 20 bytes). Each request transaction names a group
// slot and a digest index; the response transaction tells whether the group is
// enabled and the page lies within it (found), whether the page was already
// cached (hit), which cache slot holds it, the byte offset of the digest inside
// the slot and, on a miss, the flash address of the page to load. Misses fill
// free slots until slots_in_use slots are taken (zero counts as one, values
// above the cache size saturate); after that they evict the least recently
// used slot, set evicted and unmap the old page. Requests to disabled groups
// return all-zero fields and leave the cache untouched. ST_IDLE accepts a
// request and reads the page-table slot memory (registered read port);
// ST_LOOKUP updates ranks and table and loads the response register before
// the next one is accepted. A finished response waits in its own register, so
// the controller only stalls when a second response is ready while the first
// is still not taken. Page table valid bits live in flops and clear at reset;
// there is no clearing pass. Configuration writes are expected only while idle.
module lru_hash_page_cache_controller #(
  parameter int CACHE_SLOTS     = 8,
  parameter int PAGES_PER_GROUP = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [lhpc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lhpc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lhpc_req_if.sink                        req_i,
  lhpc_rsp_if.source                      rsp_o
);
  import lhpc_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Configuration registers
  lhpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Two-state sequencer: accept, then commit when the response slot is free
  lhpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Page table, LRU bookkeeping and response register
  lhpc_dp #(
    .CACHE_SLOTS     (CACHE_SLOTS),
    .PAGES_PER_GROUP (PAGES_PER_GROUP)
  ) u_dp (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_i                  (cfg),
    .cmd_i                  (cmd),
    .status_o               (status),
    .req_group_slot_i       (req_i.group_slot),
    .req_hash_index_i       (req_i.hash_index),
    .rsp_ready_i            (rsp_o.ready),
    .rsp_valid_o            (rsp_o.valid),
    .rsp_found_o            (rsp_o.found),
    .rsp_hit_o              (rsp_o.hit),
    .rsp_evicted_o          (rsp_o.evicted),
    .rsp_cache_slot_o       (rsp_o.cache_slot),
    .rsp_fetch_address_o    (rsp_o.fetch_address),
    .rsp_hash_byte_offset_o (rsp_o.hash_byte_offset)
  );

endmodule
